/* design/dust_sensor_trimmed_mean_top_assert.svh */
// Assertion macros shared by the dust sensor trimmed-mean modules.
`ifndef DUST_SENSOR_TRIMMED_MEAN_TOP_ASSERT_SVH
`define DUST_SENSOR_TRIMMED_MEAN_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Checks a property on every rising clock edge outside reset.
`define DSTM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("dstm assertion failed");
// Checks a property on every rising clock edge, during reset too.
`define DSTM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("dstm assertion failed");
`else
`define DSTM_ASSERT(lbl, prop)
`define DSTM_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* design/dstm_pkg.sv */
// Types and constants of the dust sensor trimmed-mean block.
package dstm_pkg;

  localparam int GAIN_W      = 10;
  localparam int OFFSET_W    = 10;
  localparam int CFG_W       = 10;
  localparam int DUST_W      = 13;
  localparam int OUT_DATA_W  = 16;
  localparam int SCALE_SHIFT = 12;

  localparam logic [DUST_W-1:0]   DUST_MAX     = 13'd8191;
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 10'd187;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 10'd100;

  // Configuration register indexes.
  localparam logic REG_GAIN   = 1'b0;
  localparam logic REG_OFFSET = 1'b1;

  // Handshake and tag of a word moving between pipeline stages.
  typedef struct packed {
    logic valid;
    logic src;
  } dstm_tag_t;

endpackage

/* design/dstm_accum.sv */
// Group accumulator: running count, minimum, maximum and sum, trimmed sum register.
`include "dust_sensor_trimmed_mean_top_assert.svh"

module dstm_accum #(
  parameter int SAMPLES_PER_RESULT = 8,
  parameter int SAMPLE_BITS        = 12,
  parameter int SUM_W              = 15
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   sensor_i,
  input  logic                   next_ready_i,
  output dstm_pkg::dstm_tag_t    trim_tag_o,
  output logic [SUM_W-1:0]       trim_o
);
  import dstm_pkg::*;

  localparam int CNT_W = $clog2(SAMPLES_PER_RESULT);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_RESULT - 1);

  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [SAMPLE_BITS-1:0] min_q, min_d, max_q, max_d;
  logic [SUM_W-1:0]       sum_q, sum_d, sum_base, trim_d, trim_q;
  logic                   first, closing, accept;
  logic                   valid_q, valid_d, src_q;

  assign first   = (cnt_q == '0);
  assign closing = (cnt_q == CNT_LAST);
  // Only the closing word needs room in the trimmed sum register.
  assign in_ready_o = !closing || !valid_q || next_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    if (first) begin
      min_d = sample_i;
      max_d = sample_i;
    end else begin
      min_d = (sample_i < min_q) ? sample_i : min_q;
      max_d = (sample_i > max_q) ? sample_i : max_q;
    end
    sum_base = first ? '0 : sum_q;
    sum_d    = sum_base + SUM_W'(sample_i);
    trim_d   = sum_d - SUM_W'(min_d) - SUM_W'(max_d);
    cnt_d    = closing ? '0 : cnt_q + CNT_W'(1);
    valid_d  = valid_q;
    if (valid_q && next_ready_i) begin
      valid_d = 1'b0;
    end
    if (accept && closing) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (accept) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      min_q <= min_d;
      max_q <= max_d;
      sum_q <= sum_d;
      if (closing) begin
        trim_q <= trim_d;
        src_q  <= sensor_i;
      end
    end
  end

  assign trim_tag_o.valid = valid_q;
  assign trim_tag_o.src   = src_q;
  assign trim_o           = trim_q;

  `DSTM_ASSERT(a_close_loads, accept && closing |=> valid_q)
  `DSTM_ASSERT(a_trim_holds, valid_q && !next_ready_i |=> valid_q && $stable(trim_q))
  `DSTM_ASSERT_ALWAYS(a_cnt_range, !rst_ni || (cnt_q <= CNT_LAST))

endmodule

/* design/dstm_scale.sv */
// Scaling pipeline: product with gain, shift, offset subtraction, clamp and output register.
`include "dust_sensor_trimmed_mean_top_assert.svh"

module dstm_scale #(
  parameter int SUM_W = 15
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dstm_pkg::dstm_tag_t            trim_tag_i,
  input  logic [SUM_W-1:0]               trim_i,
  output logic                           trim_ready_o,
  input  logic [dstm_pkg::GAIN_W-1:0]    gain_i,
  input  logic [dstm_pkg::OFFSET_W-1:0]  offset_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [dstm_pkg::DUST_W-1:0]    dust_o,
  output logic                           source_o
);
  import dstm_pkg::*;

  localparam int PROD_W = SUM_W + GAIN_W;
  localparam int SC_W   = PROD_W - SCALE_SHIFT;
  localparam int CMP_W  = (SC_W > OFFSET_W) ? SC_W : OFFSET_W;
  localparam int WIDE_W = (CMP_W > DUST_W) ? CMP_W : DUST_W;

  logic [PROD_W-1:0] prod_q;
  logic              prod_valid_q, prod_src_q, prod_ready;
  logic [WIDE_W-1:0] scaled_w, offset_w, diff_w;
  logic [DUST_W-1:0] dust_d, dust_q;
  logic              out_valid_q, src_q, out_load, prod_load;

  assign prod_ready   = !out_valid_q || out_ready_i;
  assign trim_ready_o = !prod_valid_q || prod_ready;
  assign prod_load    = trim_tag_i.valid && trim_ready_o;
  assign out_load     = prod_valid_q && prod_ready;

  always_comb begin
    scaled_w = WIDE_W'(prod_q[PROD_W-1:SCALE_SHIFT]);
    offset_w = WIDE_W'(offset_i);
    diff_w   = scaled_w - offset_w;
    // A scaled value at or below the offset reads as zero dust.
    if (scaled_w <= offset_w) begin
      dust_d = '0;
    end else if (diff_w > WIDE_W'(DUST_MAX)) begin
      dust_d = DUST_MAX;
    end else begin
      dust_d = diff_w[DUST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (trim_ready_o) begin
        prod_valid_q <= trim_tag_i.valid;
      end
      if (prod_ready) begin
        out_valid_q <= prod_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_load) begin
      prod_q     <= PROD_W'(trim_i) * PROD_W'(gain_i);
      prod_src_q <= trim_tag_i.src;
    end
    if (out_load) begin
      dust_q <= dust_d;
      src_q  <= prod_src_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign dust_o      = dust_q;
  assign source_o    = src_q;

  `DSTM_ASSERT(a_prod_to_out, prod_valid_q && prod_ready |=> out_valid_q)
  `DSTM_ASSERT(a_out_holds, out_valid_q && !out_ready_i |=> out_valid_q && $stable(dust_q))
  `DSTM_ASSERT(a_prod_holds, prod_valid_q && !prod_ready |=> prod_valid_q && $stable(prod_q))

endmodule

/* design/dust_sensor_trimmed_mean_top.sv */
// Top level of the dust sensor trimmed-mean converter.
//
// Samples enter on the s_axis stream: tdata carries the converter reading, tuser the sensor.
// Every SAMPLES_PER_RESULT-th accepted word closes a group; the block drops one minimum and
// one maximum from the group sum and sends dust = floor(trimmed*gain/4096) - offset, clamped
// to 0..8191, on the m_axis stream with the closing word's sensor in tuser.
// Throughput is one sample per cycle unless a closing sample waits. A result is offered after
// its group passes the trimmed sum register, gain product register and output register.
// The user must write gain and offset through cfg_we_i, cfg_idx_i and cfg_wdata_i only while
// the block is idle, unenforced by the block; reset loads gain 187 and offset 100, clears the
// sample count and empties the pipeline. When the receiver stalls, the result holds in the
// output register and the pipeline keeps two more results; samples that do not close a group
// are taken regardless; a closing sample waits only while all three result stages are full.
module dust_sensor_trimmed_mean_top #(
  parameter int SAMPLES_PER_RESULT = 8,
  parameter int SAMPLE_BITS        = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata fields from bit 0: sample, zero padding to a whole byte.
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,
  // tuser fields from bit 0: sensor.
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata fields from bit 0: dust, zero padding to a whole byte.
  output logic [dstm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // tuser fields from bit 0: source.
  output logic                               m_axis_tuser,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [dstm_pkg::CFG_W-1:0]         cfg_wdata_i
);
  import dstm_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + $clog2(SAMPLES_PER_RESULT);

  logic [GAIN_W-1:0]   gain_q;
  logic [OFFSET_W-1:0] offset_q;
  dstm_tag_t           trim_tag;
  logic [SUM_W-1:0]    trim;
  logic                trim_ready;
  logic [DUST_W-1:0]   dust;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= GAIN_RESET;
      offset_q <= OFFSET_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GAIN:   gain_q   <= cfg_wdata_i[GAIN_W-1:0];
        REG_OFFSET: offset_q <= cfg_wdata_i[OFFSET_W-1:0];
      endcase
    end
  end

  dstm_accum #(
    .SAMPLES_PER_RESULT (SAMPLES_PER_RESULT),
    .SAMPLE_BITS        (SAMPLE_BITS),
    .SUM_W              (SUM_W)
  ) u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .sample_i     (s_axis_tdata[SAMPLE_BITS-1:0]),
    .sensor_i     (s_axis_tuser),
    .next_ready_i (trim_ready),
    .trim_tag_o   (trim_tag),
    .trim_o       (trim)
  );

  dstm_scale #(
    .SUM_W (SUM_W)
  ) u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .trim_tag_i   (trim_tag),
    .trim_i       (trim),
    .trim_ready_o (trim_ready),
    .gain_i       (gain_q),
    .offset_i     (offset_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .dust_o       (dust),
    .source_o     (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_DATA_W'(dust);

endmodule
